### hw/rtl/pls_pkg.sv
// Shared types, codes and constants for the piecewise-linear sensor scale.
// Used by pls_ctrl, pls_dp and piecewise_linear_sensor_scale; no dependencies.
`default_nettype none

package pls_pkg;

    localparam int ADC_BITS      = 10;
    localparam int VAL_W         = 32;
    localparam int TL_W          = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 10;
    localparam int DEF_TABLE_DEPTH = 8;

    // |s - r0| < 2^ADC_BITS and |v1 - v0| < 2^VAL_W, so |product| < 2^MAG_W
    localparam int DIFF_W  = ADC_BITS + 1;
    localparam int DV_W    = VAL_W + 1;
    localparam int PROD_W  = DIFF_W + DV_W;
    localparam int MAG_W   = ADC_BITS + VAL_W;
    localparam int QUO_W   = MAG_W + 1;
    localparam int SUM_W   = MAG_W + 2;
    localparam int DIV_CW  = $clog2(MAG_W + 1);

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic [TL_W-1:0]       RST_TABLE_LENGTH = 4'd2;
    localparam logic [ADC_BITS-1:0]   RST_CLAMP_LOW    = 10'd0;
    localparam logic [ADC_BITS-1:0]   RST_CLAMP_HIGH   = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH = 2'd0,
        CFG_CLAMP_ENABLE = 2'd1,
        CFG_CLAMP_LOW    = 2'd2,
        CFG_CLAMP_HIGH   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE   = 1'b0,
        CMD_CONVERT = 1'b1
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_ZERO   = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FIN_BEYOND = 2'd0,
        FIN_ZERO   = 2'd1,
        FIN_ARITH  = 2'd2
    } t_fin;

    typedef struct packed {
        logic [TL_W-1:0]     table_length;
        logic                clamp_enable;
        logic [ADC_BITS-1:0] clamp_low;
        logic [ADC_BITS-1:0] clamp_high;
    } t_cfg;

    typedef struct packed {
        logic wr_point;
        logic load_sample;
        logic take_prev;
        logic take_diff;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
        t_fin fin;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic zero_width;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/pls_dp.sv
// Datapath: breakpoint memory, clamp, segment differences, multiplier,
// restoring divider and output register. Depends on pls_pkg.
`default_nettype none

module pls_dp #(
    parameter int TABLE_DEPTH = pls_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                                i_clk,
    input  wire pls_pkg::t_dp_cmd              i_cmd,
    input  wire [AW-1:0]                       i_rd_addr,
    input  wire pls_pkg::t_cfg                 i_cfg,
    input  wire [2:0]                          i_point_index,
    input  wire [pls_pkg::ADC_BITS-1:0]        i_point_raw,
    input  wire signed [pls_pkg::VAL_W-1:0]    i_point_value,
    input  wire [pls_pkg::ADC_BITS-1:0]        i_sample,
    output pls_pkg::t_dp_stat                  o_stat,
    output logic signed [pls_pkg::VAL_W-1:0]   o_value,
    output logic [1:0]                         o_status
);

    localparam int AB  = pls_pkg::ADC_BITS;
    localparam int VW  = pls_pkg::VAL_W;
    localparam int PW  = pls_pkg::PROD_W;
    localparam int MW  = pls_pkg::MAG_W;
    localparam int QW  = pls_pkg::QUO_W;
    localparam int SW  = pls_pkg::SUM_W;

    logic [AB-1:0]          r_mem_raw [TABLE_DEPTH];
    logic signed [VW-1:0]   r_mem_val [TABLE_DEPTH];

    logic [AB-1:0]          r_s;
    logic [AB-1:0]          r_rd_raw;
    logic signed [VW-1:0]   r_rd_val;
    logic [AB-1:0]          r_prev_raw;
    logic signed [VW-1:0]   r_prev_val;
    logic signed [AB:0]     r_ds;
    logic signed [AB:0]     r_den;
    logic signed [VW:0]     r_dv;
    logic signed [PW-1:0]   r_prod;
    logic                   r_neg;
    logic [AB-1:0]          r_dvsr;
    logic [AB-1:0]          r_rem;
    logic [MW-1:0]          r_quo;

    logic [AB-1:0]          n_s;
    logic signed [PW-1:0]   prod_abs;
    logic signed [AB:0]     den_abs;
    logic [AB:0]            trial;
    logic                   trial_ge;
    logic [AB:0]            trial_sub;
    logic signed [QW-1:0]   quo_s;
    logic signed [SW-1:0]   sum;
    logic [SW-VW:0]         sum_hi;
    logic signed [VW-1:0]   n_arith;
    logic [1:0]             n_arith_st;

    assign o_stat.hit        = (r_rd_raw >= r_s);
    assign o_stat.zero_width = (r_rd_raw == r_prev_raw);

    always_comb begin
        n_s = i_sample;
        if (i_cfg.clamp_enable) begin
            priority if (i_sample < i_cfg.clamp_low) begin
                n_s = i_cfg.clamp_low;
            end else if (i_sample > i_cfg.clamp_high) begin
                n_s = i_cfg.clamp_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && (32'(i_point_index) < TABLE_DEPTH)) begin
            r_mem_raw[AW'(i_point_index)] <= i_point_raw;
            r_mem_val[AW'(i_point_index)] <= i_point_value;
        end
        r_rd_raw <= r_mem_raw[i_rd_addr];
        r_rd_val <= r_mem_val[i_rd_addr];
    end

    assign prod_abs  = r_prod[PW-1] ? -r_prod : r_prod;
    assign den_abs   = r_den[AB] ? -r_den : r_den;
    assign trial     = {r_rem, r_quo[MW-1]};
    assign trial_ge  = (trial >= {1'b0, r_dvsr});
    assign trial_sub = trial - {1'b0, r_dvsr};

    always_comb begin
        quo_s  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        sum    = SW'(r_prev_val) + SW'(quo_s);
        sum_hi = sum[SW-1:VW-1];
        if ((sum_hi == '0) || (sum_hi == '1)) begin
            n_arith    = sum[VW-1:0];
            n_arith_st = pls_pkg::ST_OK;
        end else begin
            n_arith    = sum[SW-1] ? pls_pkg::VAL_MIN : pls_pkg::VAL_MAX;
            n_arith_st = pls_pkg::ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_s <= n_s;
        end
        if (i_cmd.take_prev) begin
            r_prev_raw <= r_rd_raw;
            r_prev_val <= r_rd_val;
        end
        if (i_cmd.take_diff) begin
            r_ds  <= $signed({1'b0, r_s}) - $signed({1'b0, r_prev_raw});
            r_den <= $signed({1'b0, r_rd_raw}) - $signed({1'b0, r_prev_raw});
            r_dv  <= (VW+1)'(r_rd_val) - (VW+1)'(r_prev_val);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_ds) * PW'(r_dv);
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_prod[PW-1] ^ r_den[AB];
            r_dvsr <= den_abs[AB-1:0];
            r_rem  <= '0;
            r_quo  <= prod_abs[MW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[AB-1:0] : trial[AB-1:0];
            r_quo <= {r_quo[MW-2:0], trial_ge};
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.fin)
                pls_pkg::FIN_ZERO: begin
                    o_value  <= r_prev_val;
                    o_status <= pls_pkg::ST_ZERO;
                end
                pls_pkg::FIN_ARITH: begin
                    o_value  <= n_arith;
                    o_status <= n_arith_st;
                end
                default: begin
                    o_value  <= '0;
                    o_status <= pls_pkg::ST_BEYOND;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pls_ctrl.sv
// Controller: input handshake, table search sequence, divider step count
// and output valid. Depends on pls_pkg.
`default_nettype none

module pls_ctrl #(
    parameter int TABLE_DEPTH = pls_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_cmd,
    input  wire [pls_pkg::TL_W-1:0]     i_table_length,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    input  wire pls_pkg::t_dp_stat      i_stat,
    output pls_pkg::t_dp_cmd            o_cmd,
    output logic [AW-1:0]               o_rd_addr
);

    localparam int LW = ($clog2(TABLE_DEPTH + 1) > pls_pkg::TL_W) ?
                        $clog2(TABLE_DEPTH + 1) : pls_pkg::TL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREV,
        S_CMP,
        S_MUL,
        S_ABS,
        S_DIV,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic [LW-1:0]              r_idx;
    logic [LW-1:0]              r_len;
    logic [pls_pkg::DIV_CW-1:0] r_cnt;
    pls_pkg::t_fin              r_fin;

    logic                       in_fire;
    logic [LW-1:0]              len;
    logic [LW-1:0]              idx_next;
    logic                       out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign len        = (LW'(i_table_length) > LW'(TABLE_DEPTH)) ?
                        LW'(TABLE_DEPTH) : LW'(i_table_length);
    assign idx_next   = r_idx + LW'(1);
    assign out_free   = !o_out_valid || i_out_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.fin         = r_fin;
        o_cmd.wr_point    = in_fire && (i_cmd == pls_pkg::CMD_WRITE);
        o_cmd.load_sample = in_fire && (i_cmd == pls_pkg::CMD_CONVERT);
        o_cmd.take_prev   = (r_state == S_PREV) ||
                            ((r_state == S_CMP) && !i_stat.hit);
        o_cmd.take_diff   = (r_state == S_CMP) && i_stat.hit;
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.div_init    = (r_state == S_ABS);
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.out_load    = (r_state == S_FIN) && out_free;
        unique case (r_state)
            S_IDLE:  o_rd_addr = '0;
            S_CMP:   o_rd_addr = idx_next[AW-1:0];
            default: o_rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_fin       <= pls_pkg::FIN_BEYOND;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_cmd == pls_pkg::CMD_CONVERT)) begin
                        r_idx <= LW'(1);
                        r_len <= len;
                        if (len < LW'(2)) begin
                            r_fin   <= pls_pkg::FIN_BEYOND;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_PREV;
                        end
                    end
                end
                S_PREV: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    priority if (i_stat.hit && i_stat.zero_width) begin
                        r_fin   <= pls_pkg::FIN_ZERO;
                        r_state <= S_FIN;
                    end else if (i_stat.hit) begin
                        r_fin   <= pls_pkg::FIN_ARITH;
                        r_state <= S_MUL;
                    end else if (idx_next < r_len) begin
                        r_idx <= idx_next;
                    end else begin
                        r_fin   <= pls_pkg::FIN_BEYOND;
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_cnt   <= pls_pkg::DIV_CW'(pls_pkg::MAG_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - pls_pkg::DIV_CW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/piecewise_linear_sensor_scale.sv
// Piecewise-linear sensor scale top level: configuration registers and the
// controller and datapath instances. Depends on pls_pkg, pls_ctrl, pls_dp.
//
// A write beat (cmd 0) loads one breakpoint. A convert beat (cmd 1) walks the
// table one entry a cycle from the second breakpoint, then multiplies once
// and runs a restoring divider one quotient bit a cycle over 42 bits; the
// breakpoint that matches lies at index 1 to table length - 1. A sample on a
// zero-width segment finishes without the multiply and divide, a sample
// beyond the table after every entry has been walked, and a table length
// below two without a walk. The output register holds a finished result
// while the next beat is taken.
// Configuration writes are always ready.
`default_nettype none

module piecewise_linear_sensor_scale #(
    parameter int TABLE_DEPTH = pls_pkg::DEF_TABLE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_cmd,
    input  wire [2:0]                           i_point_index,
    input  wire [pls_pkg::ADC_BITS-1:0]         i_point_raw,
    input  wire signed [pls_pkg::VAL_W-1:0]     i_point_value,
    input  wire [pls_pkg::ADC_BITS-1:0]         i_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [pls_pkg::VAL_W-1:0]    o_value,
    output logic [1:0]                          o_status,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [pls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [pls_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    pls_pkg::t_cfg      r_cfg;
    pls_pkg::t_dp_cmd   dp_cmd;
    pls_pkg::t_dp_stat  dp_stat;
    logic [AW-1:0]      rd_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_length <= pls_pkg::RST_TABLE_LENGTH;
            r_cfg.clamp_enable <= 1'b0;
            r_cfg.clamp_low    <= pls_pkg::RST_CLAMP_LOW;
            r_cfg.clamp_high   <= pls_pkg::RST_CLAMP_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pls_pkg::t_cfg_idx'(i_cfg_index))
                pls_pkg::CFG_TABLE_LENGTH:
                    r_cfg.table_length <= i_cfg_data[pls_pkg::TL_W-1:0];
                pls_pkg::CFG_CLAMP_ENABLE:
                    r_cfg.clamp_enable <= i_cfg_data[0];
                pls_pkg::CFG_CLAMP_LOW:
                    r_cfg.clamp_low <= i_cfg_data[pls_pkg::ADC_BITS-1:0];
                pls_pkg::CFG_CLAMP_HIGH:
                    r_cfg.clamp_high <= i_cfg_data[pls_pkg::ADC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    pls_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_table_length (r_cfg.table_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_rd_addr      (rd_addr)
    );

    pls_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_rd_addr     (rd_addr),
        .i_cfg         (r_cfg),
        .i_point_index (i_point_index),
        .i_point_raw   (i_point_raw),
        .i_point_value (i_point_value),
        .i_sample      (i_sample),
        .o_stat        (dp_stat),
        .o_value       (o_value),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire
